@@ sv/mcid_pkg.sv @@
// Shared types and constants for the multi-channel input debouncer.
// No dependencies.
`default_nettype none

package mcid_pkg;

    localparam int NUM_CH    = 7;
    localparam int CH_IDX_W  = 3;
    localparam int FILT_W    = 8;
    localparam int OP_W      = 2;

    typedef logic [NUM_CH-1:0]   t_ch_vec;
    typedef logic [CH_IDX_W-1:0] t_ch_idx;
    typedef logic [FILT_W-1:0]   t_filt;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE   = 2'd0,
        OP_TICK     = 2'd1,
        OP_READ_ONE = 2'd2,
        OP_READ_ALL = 2'd3
    } t_op;

    // Per-channel control from the top level.
    typedef struct packed {
        logic  stamp;     // load change time with current ms count
        logic  cfg_we;    // write filter time
        t_filt cfg_data;
    } t_chan_ctl;

endpackage

`default_nettype wire

@@ sv/mcid_if.sv @@
// Valid/ready channel interfaces for the debouncer: input items, results
// and configuration writes. Depends on mcid_pkg.
`default_nettype none

interface mcid_in_if import mcid_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [NUM_CH-1:0]   pin_levels;
    logic [CH_IDX_W-1:0] channel;

    modport source (output valid, output op, output pin_levels, output channel,
                    input ready);
    modport sink   (input valid, input op, input pin_levels, input channel,
                    output ready);
endinterface

interface mcid_out_if import mcid_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              channel_value;
    logic [NUM_CH-1:0] all_values;

    modport source (output valid, output channel_value, output all_values,
                    input ready);
    modport sink   (input valid, input channel_value, input all_values,
                    output ready);
endinterface

interface mcid_cfg_if import mcid_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CH_IDX_W-1:0] index;
    logic [FILT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/mcid_chan.sv @@
// One debounce channel: filter time register, change timestamp and the
// elapsed-time compare. Depends on mcid_pkg.
`default_nettype none

module mcid_chan
    import mcid_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire t_chan_ctl            i_ctl,
    output logic                      o_settled
);

    t_filt                r_filt;
    logic [TIME_BITS-1:0] r_change;
    logic [TIME_BITS-1:0] elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt   <= '0;
            r_change <= '0;
        end else begin
            if (i_ctl.cfg_we) begin
                r_filt <= i_ctl.cfg_data;
            end
            if (i_ctl.stamp) begin
                r_change <= i_now;
            end
        end
    end

    // modulo 2^TIME_BITS difference, wrap handled by truncation
    assign elapsed   = i_now - r_change;
    assign o_settled = (elapsed >= TIME_BITS'(r_filt));

endmodule

`default_nettype wire

@@ sv/multi_channel_input_debouncer.sv @@
// Seven-channel timestamp debounce filter, top level.
// Depends on mcid_pkg, mcid_if (interfaces) and mcid_chan.
//
//  port    dir  handshake     payload
//  i_in    in   valid/ready   op[1:0], pin_levels[6:0], channel[2:0]
//  o_out   out  valid/ready   channel_value, all_values[6:0]
//  i_cfg   in   valid/ready   index[2:0], data[7:0] (filter time, ms)
//
// One item per cycle while i_in.ready is high; each transfer yields its result
// in the next cycle from the output register. i_in.ready drops only while a
// result waits and o_out.ready is low. i_cfg.ready is always high.
// Synchronous active-low reset: snapshot all ones, everything else zero.
`default_nettype none

module multi_channel_input_debouncer
    import mcid_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mcid_in_if.sink    i_in,
    mcid_out_if.source o_out,
    mcid_cfg_if.sink   i_cfg
);

    logic [TIME_BITS-1:0] r_now, n_now;
    t_ch_vec              r_snap, n_snap;
    t_ch_vec              r_acc, n_acc;
    logic                 r_out_valid;
    logic                 r_cv, n_cv;
    t_ch_vec              r_all;

    logic      in_xfer;
    t_op       op;
    t_ch_vec   stamp;
    t_ch_vec   settled;
    t_ch_vec   rd_mask;
    t_ch_vec   one_mask;
    t_ch_vec   upd;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign op          = t_op'(i_in.op);

    // channel 7 shifts out of range and selects nothing
    assign one_mask = t_ch_vec'(8'd1 << i_in.channel);

    for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
        t_chan_ctl ctl;

        assign ctl.stamp    = stamp[g];
        assign ctl.cfg_we   = i_cfg.valid && (i_cfg.index == CH_IDX_W'(g));
        assign ctl.cfg_data = i_cfg.data;

        mcid_chan #(
            .TIME_BITS (TIME_BITS)
        ) u_chan (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_now     (r_now),
            .i_ctl     (ctl),
            .o_settled (settled[g])
        );
    end

    always_comb begin
        n_now   = r_now;
        n_snap  = r_snap;
        stamp   = '0;
        rd_mask = '0;
        if (in_xfer) begin
            unique case (op)
                OP_SAMPLE: begin
                    stamp  = r_snap ^ i_in.pin_levels;
                    n_snap = i_in.pin_levels;
                end
                OP_TICK:     n_now   = r_now + 1'b1;
                OP_READ_ONE: rd_mask = one_mask;
                OP_READ_ALL: rd_mask = '1;
                default: ;
            endcase
        end
        upd   = rd_mask & settled;
        n_acc = (r_acc & ~upd) | (~r_snap & upd);
        n_cv  = (op == OP_READ_ONE) && |(n_acc & one_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_snap      <= '1;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_cv        <= 1'b0;
            r_all       <= '0;
        end else begin
            r_now  <= n_now;
            r_snap <= n_snap;
            r_acc  <= n_acc;
            if (in_xfer) begin
                r_out_valid <= 1'b1;
                r_cv        <= n_cv;
                r_all       <= n_acc;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.channel_value = r_cv;
    assign o_out.all_values    = r_all;

endmodule

`default_nettype wire

@@ sv/mcid_checker.sv @@
// Port-level checks for the debouncer, bound to the top level.
// Depends on mcid_pkg and multi_channel_input_debouncer.
`default_nettype none

module mcid_checker
    import mcid_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic [OP_W-1:0]     i_in_op,
    input wire logic [CH_IDX_W-1:0] i_in_channel,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic                i_out_cv,
    input wire logic [NUM_CH-1:0]   i_out_all
);

    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> i_out_valid)
        else $error("no result after input transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_all)
            && $stable(i_out_cv))
        else $error("stalled result changed");

    a_cv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_op != OP_READ_ONE) |=> !i_out_cv)
        else $error("channel_value set for non read-one op");

    a_no_read_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && ((i_in_op == OP_SAMPLE) || (i_in_op == OP_TICK))
            |=> i_out_all == $past(i_out_all))
        else $error("accepted values changed without a read");

    a_cv_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_op == OP_READ_ONE)
            |=> i_out_cv == ((((8'(i_out_all)) >> $past(i_in_channel)) & 8'd1) != 8'd0))
        else $error("channel_value disagrees with all_values");

endmodule

bind multi_channel_input_debouncer mcid_checker u_mcid_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_op      (i_in.op),
    .i_in_channel (i_in.channel),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_cv     (o_out.channel_value),
    .i_out_all    (o_out.all_values)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for multi_channel_input_debouncer: random and directed items,
// results checked against a cycle-free debounce predictor kept in the testbench.
// Depends on mcid_pkg, the mcid_*_if interfaces and the debouncer top level.

module tb_top;
    import mcid_pkg::*;

    localparam int TIME_BITS   = 16;
    localparam int HOLD_CYCLES = 48;

    typedef struct packed {
        logic    channel_value;
        t_ch_vec all_values;
    } t_reading;

    logic clk;
    logic rst_n;

    mcid_in_if  in_if ();
    mcid_out_if out_if ();
    mcid_cfg_if cfg_if ();

    multi_channel_input_debouncer #(
        .TIME_BITS(TIME_BITS)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    always #5 clk = ~clk;

    // Predictor state
    logic [TIME_BITS-1:0] now_ms;
    logic [TIME_BITS-1:0] stamp_ms [NUM_CH];
    t_ch_vec              pin_snap;
    t_ch_vec              accepted;
    t_filt                filt_ms [NUM_CH];

    t_reading pending_readings [$];
    int       mismatches;

    // Stimulus bookkeeping
    int              items_sent;
    t_ch_vec         pins_driven;
    int              tx_idle_pct;
    int              rx_idle_pct;
    bit              hold_req;
    int              hold_left;

    function automatic void settle_channel(int c);
        logic [TIME_BITS-1:0] elapsed;
        elapsed = now_ms - stamp_ms[c];
        if (elapsed >= filt_ms[c]) accepted[c] = ~pin_snap[c];
    endfunction

    function automatic t_reading predict_debounce(t_op op, t_ch_vec pins, t_ch_idx ch);
        t_reading r;
        int       c;
        r.channel_value = 1'b0;
        case (op)
            OP_SAMPLE: begin
                for (c = 0; c < NUM_CH; c++)
                    if (pin_snap[c] != pins[c]) stamp_ms[c] = now_ms;
                pin_snap = pins;
            end
            OP_TICK: now_ms = now_ms + 1'b1;
            OP_READ_ONE: begin
                // channel 7 is out of range: nothing changes
                if (ch < NUM_CH) begin
                    settle_channel(ch);
                    r.channel_value = accepted[ch];
                end
            end
            default: begin
                for (c = 0; c < NUM_CH; c++) settle_channel(c);
            end
        endcase
        r.all_values = accepted;
        return r;
    endfunction

    task automatic report_mismatch(string what, int exp_v, int got_v);
        $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    // Prediction on every input transfer, comparison on every result transfer
    always @(posedge clk) begin
        t_reading want;
        if (rst_n) begin
            if (in_if.valid && in_if.ready)
                pending_readings.push_back(predict_debounce(t_op'(in_if.op),
                                                            in_if.pin_levels,
                                                            in_if.channel));
            if (cfg_if.valid && cfg_if.ready && cfg_if.index < NUM_CH)
                filt_ms[cfg_if.index] = cfg_if.data;
            if (out_if.valid && out_if.ready) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, out_if.all_values);
                end else begin
                    want = pending_readings.pop_front();
                    if (out_if.channel_value !== want.channel_value)
                        report_mismatch("channel_value", want.channel_value,
                                        out_if.channel_value);
                    if (out_if.all_values !== want.all_values)
                        report_mismatch("all_values", want.all_values, out_if.all_values);
                end
            end
        end
    end

    // Result receiver: random stalls plus a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic t_ch_vec rand_pins();
        return t_ch_vec'($urandom);
    endfunction

    function automatic t_ch_idx rand_ch();
        return t_ch_idx'($urandom_range(0, 7));
    endfunction

    task automatic send_item(t_op op, t_ch_vec pins, t_ch_idx ch);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.op         <= op;
        in_if.pin_levels <= pins;
        in_if.channel    <= ch;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        items_sent++;
        if (op == OP_SAMPLE) pins_driven = pins;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes all filter registers, plus the unused index 7 with junk data
    task automatic configure(t_filt vals [NUM_CH]);
        int i;
        drain_results();
        for (i = 0; i <= NUM_CH; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= t_ch_idx'(i);
            cfg_if.data  <= (i < NUM_CH) ? vals[i] : t_filt'($urandom);
            @(posedge clk);
            while (!cfg_if.ready) @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Press or release on one channel with contact chatter, then a run of ticks and reads
    task automatic run_bounce();
        int      c;
        int      n;
        int      k;
        t_ch_vec pins;
        c = $urandom_range(0, NUM_CH - 1);
        repeat ($urandom_range(1, 3)) begin
            pins = pins_driven ^ (t_ch_vec'(1) << c);
            if ($urandom_range(0, 4) == 0) pins[$urandom_range(0, NUM_CH - 1)] ^= 1'b1;
            send_item(OP_SAMPLE, pins, rand_ch());
            if ($urandom_range(0, 1) == 1) send_item(OP_TICK, rand_pins(), rand_ch());
        end
        if (filt_ms[c] <= 16) n = $urandom_range(0, filt_ms[c] + 2);
        else if ($urandom_range(0, 19) == 0) n = filt_ms[c] + 1;
        else n = $urandom_range(0, 10);
        for (k = 0; k < n; k++) begin
            send_item(OP_TICK, rand_pins(), rand_ch());
            if ($urandom_range(0, 4) == 0) send_item(OP_READ_ONE, rand_pins(), t_ch_idx'(c));
        end
        if ($urandom_range(0, 1) == 1) send_item(OP_READ_ONE, rand_pins(), t_ch_idx'(c));
        else send_item(OP_READ_ALL, rand_pins(), rand_ch());
    endtask

    task automatic test_reset_values();
        send_item(OP_READ_ALL, rand_pins(), rand_ch());
        send_item(OP_READ_ONE, rand_pins(), 3'd0);
        send_item(OP_READ_ONE, rand_pins(), 3'd7);
    endtask

    task automatic test_filter_extremes();
        t_filt plan [NUM_CH];
        plan = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd1, 8'd0};
        configure(plan);
        send_item(OP_SAMPLE, 7'h00, 3'd0);
        send_item(OP_READ_ALL, 7'h7F, 3'd7);
        send_item(OP_TICK, 7'h00, 3'd0);
        send_item(OP_READ_ALL, 7'h00, 3'd0);
        send_item(OP_READ_ONE, 7'h7F, 3'd1);
        send_item(OP_READ_ONE, 7'h7F, 3'd7);
        send_item(OP_SAMPLE, 7'h7F, 3'd7);
        send_item(OP_READ_ONE, 7'h00, 3'd0);
        send_item(OP_READ_ALL, 7'h7F, 3'd3);
        send_item(OP_SAMPLE, 7'h55, 3'd5);
        send_item(OP_TICK, 7'h2A, 3'd2);
        send_item(OP_READ_ONE, 7'h2A, 3'd6);
        send_item(OP_READ_ALL, 7'h55, 3'd4);
    endtask

    task automatic test_random_phase(int lo, int hi, int n_items);
        t_filt plan [NUM_CH];
        int    c;
        int    stop_at;
        for (c = 0; c < NUM_CH; c++) plan[c] = t_filt'($urandom_range(lo, hi));
        configure(plan);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 70)
                run_bounce();
            else
                send_item(t_op'($urandom_range(0, 3)), rand_pins(), rand_ch());
        end
    endtask

    // Receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        tx_idle_pct = 0;
        hold_req = 1'b1;
        repeat (24) send_item(t_op'($urandom_range(0, 3)), rand_pins(), rand_ch());
        tx_idle_pct = 33;
    endtask

    // Exact threshold on a 20 ms channel, both sides never idling
    task automatic test_threshold_run();
        t_filt plan [NUM_CH];
        plan = '{8'd20, 8'd0, 8'd255, 8'd5, 8'd5, 8'd5, 8'd5};
        configure(plan);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(OP_SAMPLE, pins_driven ^ 7'h07, 3'd0);
        send_item(OP_READ_ALL, rand_pins(), rand_ch());
        repeat (19) send_item(OP_TICK, rand_pins(), rand_ch());
        send_item(OP_READ_ONE, rand_pins(), 3'd0);
        send_item(OP_READ_ONE, rand_pins(), 3'd1);
        send_item(OP_TICK, rand_pins(), rand_ch());
        send_item(OP_READ_ONE, rand_pins(), 3'd0);
        repeat (40) send_item(t_op'($urandom_range(0, 3)), rand_pins(), rand_ch());
        send_item(OP_READ_ALL, rand_pins(), rand_ch());
        tx_idle_pct = 33;
        rx_idle_pct = 33;
    endtask

    initial begin
        int c;
        clk = 1'b0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.op = OP_SAMPLE;
        in_if.pin_levels = '1;
        in_if.channel = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        now_ms = '0;
        pin_snap = '1;
        accepted = '0;
        for (c = 0; c < NUM_CH; c++) begin
            stamp_ms[c] = '0;
            filt_ms[c] = '0;
        end
        mismatches = 0;
        items_sent = 0;
        pins_driven = '1;
        tx_idle_pct = 33;
        rx_idle_pct = 33;
        hold_req = 1'b0;
        hold_left = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_filter_extremes();
        test_random_phase(0, 6, 230);
        test_random_phase(0, 0, 230);
        test_random_phase(255, 255, 230);
        test_random_phase(0, 255, 230);
        test_backpressure();
        test_threshold_run();

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
